FILE: rtl/nalsp_pkg.sv
// Types and constants shared by the Annex B NAL unit splitter.
package nalsp_pkg;

	typedef enum logic [1:0] {
		PH_SEEK  = 2'd0,
		PH_UNIT  = 2'd1,
		PH_DRAIN = 2'd2
	} phase_t;

	localparam logic [2:0] SC_SHORT = 3'd3;
	localparam logic [2:0] SC_LONG  = 3'd4;

	localparam logic [7:0] TYPE_MASK = 8'h1f;
	localparam logic [4:0] NAL_IDR   = 5'd5;
	localparam logic [4:0] NAL_SEI   = 5'd6;
	localparam logic [4:0] NAL_SPS   = 5'd7;
	localparam logic [4:0] NAL_PPS   = 5'd8;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_START = 2'd1;
	localparam logic [1:0] ST_TOO_MANY = 2'd2;

	localparam logic [5:0]  UNITS_MAX       = 6'd63;
	localparam logic [27:0] FRAME_BYTES_MAX = 28'h0FFFFFFF;
	localparam logic [5:0]  MAX_NALS_RESET  = 6'd10;

	localparam int OUT_DATA_W = 80;

endpackage

FILE: rtl/h264_annexb_nal_splitter.sv
// H.264 Annex B start code parser: NAL unit records with frame grouping.
//
// Takes one stream byte per word on s_axis (tlast marks the stream's final byte) and
// emits one record per NAL unit on m_axis when the next 3- or 4-byte start code completes
// or at the final byte. A byte is registered on entry, all parsing and frame accounting
// is one short combinational pass over that register and the parser state, and the record
// lands in an output register, so the block takes one byte every cycle while m_axis keeps
// up; the only loop is the per-byte state update. Units of type SEI, SPS and PPS are carried
// into the frame, any other type closes it (IDR for type 5); reaching the frame unit limit
// gives an error record and restarts the frame count. A stream that does not open with a
// start code gives one error record and is then dropped up to its final byte. All parser
// state returns to reset after the final byte, so a new stream may follow at once.
module h264_annexb_nal_splitter
	import nalsp_pkg::*;
#(
	parameter int LENGTH_BITS          = 24,
	parameter int FRAME_UNIT_LIMIT_MAX = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,       // max_frame_nals, the frame unit limit, capped at FRAME_UNIT_LIMIT_MAX
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,    // data_byte
	input  logic        s_axis_tlast,    // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// unit_len[23:0], start_code_size[26:24], header_byte[34:27], unit_type[39:35],
	// frame_end[40], frame_is_idr[41], frame_unit_count[47:42], frame_bytes[75:48], zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,    // status
	output logic        m_axis_tlast     // stream_end
);

	localparam int LB = LENGTH_BITS;
	localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};
	localparam logic [6:0] LIMIT_MAX = 7'(FRAME_UNIT_LIMIT_MAX);

	// configuration
	logic [5:0] max_nals_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// parser state
	phase_t         phase_q;
	logic [23:0]    hist_q;
	logic [LB-1:0]  ubc_q;
	logic [2:0]     ccs_q;
	logic [7:0]     hdr_q;
	logic [5:0]     units_q;
	logic [27:0]    fbytes_q;

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [1:0]            out_status_q;
	logic                  out_end_q;

	logic go;

	// next state
	phase_t         phase_d;
	logic [LB-1:0]  ubc_d;
	logic [2:0]     ccs_d;
	logic [7:0]     hdr_d;
	logic [5:0]     units_d;
	logic [27:0]    fbytes_d;

	// record being formed
	logic           emit_unit, emit_err;
	logic [LB-1:0]  em_len;
	logic [2:0]     em_code;
	logic [7:0]     em_hdr;

	logic [LB-1:0]  incl, payload;
	logic [7:0]     h0, h1, h2;
	logic [2:0]     nsz;
	logic [4:0]     utype;
	logic [5:0]     uinc;
	logic [32:0]    fsum;
	logic [27:0]    fsat;
	logic [6:0]     limit;
	logic           over, carry;
	logic           r_fend, r_idr;
	logic [1:0]     r_status;
	logic [5:0]     r_units;
	logic [27:0]    r_fbytes;
	logic [23:0]    r_len24;
	logic           res_valid;

	always_comb begin
		h0 = hist_q[7:0];
		h1 = hist_q[15:8];
		h2 = hist_q[23:16];
		incl = (ubc_q == LEN_MAX) ? LEN_MAX : ubc_q + LB'(1);
		payload = (ubc_q >= LB'(ccs_q)) ? ubc_q - LB'(ccs_q) : '0;
		nsz = (payload >= LB'(3) && h2 == 8'd0) ? SC_LONG : SC_SHORT;

		phase_d  = phase_q;
		ubc_d    = ubc_q;
		ccs_d    = ccs_q;
		hdr_d    = hdr_q;
		emit_unit = 1'b0;
		emit_err  = 1'b0;
		em_len   = '0;
		em_code  = ccs_q;
		em_hdr   = hdr_q;

		unique case (phase_q)
			PH_SEEK: begin
				// leading zeros counted in ubc_q until the 01 byte; a fourth zero fails
				if (ubc_q >= LB'(2) && byte_s1 == 8'd1) begin
					em_code  = (ubc_q == LB'(2)) ? SC_SHORT : SC_LONG;
					phase_d  = PH_UNIT;
					ubc_d    = LB'(em_code);
					ccs_d    = em_code;
					hdr_d    = 8'd0;
					emit_unit = last_s1;
					em_len   = LB'(em_code);
					em_hdr   = 8'd0;
				end else if (byte_s1 == 8'd0 && ubc_q <= LB'(2)) begin
					ubc_d    = incl;
					emit_err = last_s1;
				end else begin
					emit_err = 1'b1;
					phase_d  = PH_DRAIN;
				end
			end
			PH_UNIT: begin
				if (last_s1) begin
					emit_unit = 1'b1;
					em_len   = incl;
					em_hdr   = (payload == '0) ? byte_s1 : hdr_q;
				end else if (byte_s1 == 8'd1 && h0 == 8'd0 && h1 == 8'd0
						&& payload >= LB'(2)) begin
					emit_unit = 1'b1;
					em_len   = (incl == LEN_MAX) ? LEN_MAX : incl - LB'(nsz);
					ubc_d    = LB'(nsz);
					ccs_d    = nsz;
					hdr_d    = 8'd0;
				end else begin
					if (payload == '0) hdr_d = byte_s1;
					ubc_d = incl;
				end
			end
			PH_DRAIN: begin
			end
			default: begin
				phase_d = PH_SEEK;
			end
		endcase

		// frame accounting for a unit record
		utype = em_hdr[4:0] & TYPE_MASK[4:0];
		uinc  = (units_q == UNITS_MAX) ? UNITS_MAX : units_q + 6'd1;
		fsum  = 33'(fbytes_q) + 33'(em_len);
		fsat  = (fsum > 33'(FRAME_BYTES_MAX)) ? FRAME_BYTES_MAX : fsum[27:0];
		limit = ({1'b0, max_nals_q} > LIMIT_MAX) ? LIMIT_MAX : {1'b0, max_nals_q};
		over  = {1'b0, uinc} >= limit;
		carry = (utype == NAL_SEI) || (utype == NAL_SPS) || (utype == NAL_PPS);

		units_d  = units_q;
		fbytes_d = fbytes_q;
		r_fend   = 1'b0;
		r_idr    = 1'b0;
		r_status = ST_OK;
		if (emit_unit) begin
			if (over) begin
				r_status = ST_TOO_MANY;
				units_d  = '0;
				fbytes_d = '0;
			end else if (carry) begin
				units_d  = uinc;
				fbytes_d = fsat;
			end else begin
				r_fend   = 1'b1;
				r_idr    = (utype == NAL_IDR);
				units_d  = '0;
				fbytes_d = '0;
			end
		end

		r_len24  = 24'(em_len);
		r_units  = uinc;
		r_fbytes = fsat;
		res_valid = emit_unit || emit_err;
	end

	assign go = valid_s1 && (!res_valid || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_nals_q <= MAX_NALS_RESET;
		end else if (cfg_we) begin
			max_nals_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEEK;
			hist_q   <= '0;
			ubc_q    <= '0;
			ccs_q    <= '0;
			hdr_q    <= '0;
			units_q  <= '0;
			fbytes_q <= '0;
		end else if (go) begin
			if (last_s1) begin
				// end of stream: all parser state back to reset
				phase_q  <= PH_SEEK;
				hist_q   <= '0;
				ubc_q    <= '0;
				ccs_q    <= '0;
				hdr_q    <= '0;
				units_q  <= '0;
				fbytes_q <= '0;
			end else begin
				phase_q  <= phase_d;
				hist_q   <= {hist_q[15:0], byte_s1};
				ubc_q    <= ubc_d;
				ccs_q    <= ccs_d;
				hdr_q    <= hdr_d;
				units_q  <= units_d;
				fbytes_q <= fbytes_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_valid) begin
			out_end_q <= last_s1;
			if (emit_err) begin
				out_data_q   <= '0;
				out_status_q <= ST_NO_START;
			end else begin
				out_data_q   <= {4'd0, r_fbytes, r_units, r_idr, r_fend, utype,
					em_hdr, em_code, r_len24};
				out_status_q <= r_status;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_end_q;

endmodule
